// ===== rtl/ppgd_pkg.sv =====
`default_nettype none

package ppgd_pkg;

    // Default reading width of the red and infrared levels
    localparam int SAMPLE_BITS_DEF = 24;

    // Field and register widths
    localparam int TS_BITS        = 32;
    localparam int SEQ_BITS       = 32;
    localparam int FLAG_BITS      = 8;
    localparam int COUNT_BITS     = 32;
    localparam int RATE_BITS      = 16;
    localparam int PERIOD_BITS    = 20;
    localparam int MASK_BITS      = 8;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 32;
    localparam int STATUS_BITS    = 2;

    // The only input rate that the decimator handles
    localparam logic [RATE_BITS-1:0] SUPPORTED_RATE_HZ = 16'd200;

    // Register reset values
    localparam logic [RATE_BITS-1:0]   RATE_RESET   = 16'd200;
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 20'd5000;
    localparam logic [MASK_BITS-1:0]   MASK_RESET   = 8'd3;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_RATE  = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_PERIOD = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DISC_MASK    = 8'd2;

    // Counter step
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = 32'd1;
    localparam logic [SEQ_BITS-1:0]   SEQ_ONE   = 32'd1;

    // Per-item status codes
    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_ACCEPTED     = 2'd0,
        STATUS_RATE_IGNORED = 2'd1,
        STATUS_DROPPED      = 2'd2,
        STATUS_RESTARTED    = 2'd3
    } status_t;

    // Current register values and a restart strobe from a changing write
    typedef struct packed {
        logic [RATE_BITS-1:0]   rate_hz;
        logic [PERIOD_BITS-1:0] period_us;
        logic [MASK_BITS-1:0]   disc_mask;
        logic                   restart;
    } cfg_state_t;

    // Status part of one result item
    typedef struct packed {
        logic                  pair_valid;
        status_t               status;
        logic [COUNT_BITS-1:0] source_count;
        logic [COUNT_BITS-1:0] pair_count;
        logic [COUNT_BITS-1:0] restart_count;
    } res_info_t;

endpackage

`default_nettype wire

// ===== rtl/ppgd_if.sv =====
`default_nettype none

// Sample channel
interface ppgd_in_if #(
    parameter int SAMPLE_BITS = ppgd_pkg::SAMPLE_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic [ppgd_pkg::TS_BITS-1:0]   capture_time;
    logic [ppgd_pkg::SEQ_BITS-1:0]  sequence_number;
    logic [ppgd_pkg::FLAG_BITS-1:0] sample_flags;
    logic [SAMPLE_BITS-1:0]         red_level;
    logic [SAMPLE_BITS-1:0]         ir_level;

    modport source (
        output valid, capture_time, sequence_number, sample_flags, red_level, ir_level,
        input  ready
    );
    modport sink (
        input  valid, capture_time, sequence_number, sample_flags, red_level, ir_level,
        output ready
    );
endinterface

// Result channel
interface ppgd_out_if #(
    parameter int SAMPLE_BITS = ppgd_pkg::SAMPLE_BITS_DEF
);
    logic                             valid;
    logic                             ready;
    logic                             pair_valid;
    logic [SAMPLE_BITS-1:0]           red_average;
    logic [SAMPLE_BITS-1:0]           ir_average;
    logic [ppgd_pkg::STATUS_BITS-1:0] sample_status;
    logic [ppgd_pkg::COUNT_BITS-1:0]  source_count;
    logic [ppgd_pkg::COUNT_BITS-1:0]  pair_count;
    logic [ppgd_pkg::COUNT_BITS-1:0]  restart_count;

    modport source (
        output valid, pair_valid, red_average, ir_average, sample_status,
               source_count, pair_count, restart_count,
        input  ready
    );
    modport sink (
        input  valid, pair_valid, red_average, ir_average, sample_status,
               source_count, pair_count, restart_count,
        output ready
    );
endinterface

// Register write channel
interface ppgd_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ppgd_pkg::CFG_INDEX_BITS-1:0] index;
    logic [ppgd_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/ppgd_cfg_regs.sv =====
`default_nettype none

module ppgd_cfg_regs (
    input  wire logic           clk,
    input  wire logic           rst_n,
    ppgd_cfg_if.sink            cfg,
    output ppgd_pkg::cfg_state_t cfg_state
);
    import ppgd_pkg::*;

    logic [RATE_BITS-1:0]   rate_reg,   rate_next;
    logic [PERIOD_BITS-1:0] period_reg, period_next;
    logic [MASK_BITS-1:0]   mask_reg,   mask_next;
    logic                   write_fire;
    logic                   changed;

    // Writes are always taken
    assign cfg.ready  = 1'b1;
    assign write_fire = cfg.valid && cfg.ready;

    // Mask the value to the register width; flag a change as a restart
    always_comb
    begin
        rate_next   = rate_reg;
        period_next = period_reg;
        mask_next   = mask_reg;
        changed     = 1'b0;
        if (write_fire)
        begin
            case (cfg.index)
                REG_SAMPLE_RATE:
                begin
                    rate_next = cfg.data[RATE_BITS-1:0];
                    changed   = (rate_next != rate_reg);
                end
                REG_SAMPLE_PERIOD:
                begin
                    period_next = cfg.data[PERIOD_BITS-1:0];
                    changed     = (period_next != period_reg);
                end
                REG_DISC_MASK:
                begin
                    mask_next = cfg.data[MASK_BITS-1:0];
                    changed   = (mask_next != mask_reg);
                end
                default:
                begin
                    changed = 1'b0;
                end
            endcase
        end
    end

    // Hold register values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg   <= RATE_RESET;
            period_reg <= PERIOD_RESET;
            mask_reg   <= MASK_RESET;
        end
        else
        begin
            rate_reg   <= rate_next;
            period_reg <= period_next;
            mask_reg   <= mask_next;
        end
    end

    assign cfg_state.rate_hz   = rate_reg;
    assign cfg_state.period_us = period_reg;
    assign cfg_state.disc_mask = mask_reg;
    assign cfg_state.restart   = changed;

endmodule

`default_nettype wire

// ===== rtl/ppgd_step.sv =====
`default_nettype none

module ppgd_step #(
    parameter int SAMPLE_BITS = ppgd_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire ppgd_pkg::cfg_state_t           cfg_state,
    input  wire logic                           fire,
    input  wire logic [ppgd_pkg::TS_BITS-1:0]   capture_time,
    input  wire logic [ppgd_pkg::SEQ_BITS-1:0]  sequence_number,
    input  wire logic [ppgd_pkg::FLAG_BITS-1:0] sample_flags,
    input  wire logic [SAMPLE_BITS-1:0]         red_level,
    input  wire logic [SAMPLE_BITS-1:0]         ir_level,
    output ppgd_pkg::res_info_t                 info,
    output logic [SAMPLE_BITS-1:0]              red_average,
    output logic [SAMPLE_BITS-1:0]              ir_average
);
    import ppgd_pkg::*;

    // Stream state
    logic                  have_prev_reg,  have_prev_next;
    logic [TS_BITS-1:0]    prev_ts_reg,    prev_ts_next;
    logic [SEQ_BITS-1:0]   prev_seq_reg,   prev_seq_next;
    logic                  have_half_reg,  have_half_next;
    logic [COUNT_BITS-1:0] accepted_reg,   accepted_next;
    logic [COUNT_BITS-1:0] pairs_reg,      pairs_next;
    logic [COUNT_BITS-1:0] restarts_reg,   restarts_next;
    logic [SAMPLE_BITS-1:0] held_red_reg;
    logic [SAMPLE_BITS-1:0] held_ir_reg;

    logic                  rate_ok;
    logic                  backward;
    logic                  flagged;
    logic                  seq_gap;
    logic                  ts_gap;
    logic                  take;
    logic                  restart;
    logic                  load_half;
    logic                  half_base;
    logic [SAMPLE_BITS:0]  red_sum;
    logic [SAMPLE_BITS:0]  ir_sum;
    logic [TS_BITS-1:0]    ts_expect;

    // Continuity checks against the previous item
    assign rate_ok   = (cfg_state.rate_hz == SUPPORTED_RATE_HZ);
    assign backward  = have_prev_reg &&
                       ((capture_time <= prev_ts_reg) || (sequence_number == prev_seq_reg));
    assign flagged   = ((sample_flags & cfg_state.disc_mask) != '0);
    assign ts_expect = prev_ts_reg + TS_BITS'(cfg_state.period_us);
    assign seq_gap   = have_prev_reg && (sequence_number != prev_seq_reg + SEQ_ONE);
    assign ts_gap    = have_prev_reg && (capture_time != ts_expect);
    assign take      = rate_ok && !backward;

    // Rounded pair averages, half-way rounds up
    assign red_sum = {1'b0, held_red_reg} + {1'b0, red_level} + (SAMPLE_BITS+1)'(1);
    assign ir_sum  = {1'b0, held_ir_reg} + {1'b0, ir_level} + (SAMPLE_BITS+1)'(1);

    // Next state and result for one item
    always_comb
    begin
        have_prev_next = have_prev_reg;
        prev_ts_next   = prev_ts_reg;
        prev_seq_next  = prev_seq_reg;
        have_half_next = have_half_reg;
        accepted_next  = accepted_reg;
        pairs_next     = pairs_reg;
        restarts_next  = restarts_reg;
        restart        = 1'b0;
        load_half      = 1'b0;
        half_base      = have_half_reg;
        info.pair_valid = 1'b0;
        info.status     = STATUS_ACCEPTED;
        red_average     = '0;
        ir_average      = '0;

        if (cfg_state.restart)
        begin
            restart = 1'b1;
        end
        else if (fire)
        begin
            if (!rate_ok)
            begin
                info.status = STATUS_RATE_IGNORED;
            end
            else if (backward)
            begin
                restart     = 1'b1;
                info.status = STATUS_DROPPED;
            end
            else if (flagged || seq_gap || ts_gap)
            begin
                restart     = 1'b1;
                info.status = STATUS_RESTARTED;
            end
        end

        // Clear the stream on a restart
        if (restart)
        begin
            have_prev_next = 1'b0;
            prev_ts_next   = '0;
            prev_seq_next  = '0;
            have_half_next = 1'b0;
            accepted_next  = '0;
            pairs_next     = '0;
            restarts_next  = restarts_reg + COUNT_ONE;
            half_base      = 1'b0;
        end

        // Accept the item: hold the first half or emit the pair
        if (!cfg_state.restart && fire && take)
        begin
            accepted_next  = accepted_next + COUNT_ONE;
            prev_ts_next   = capture_time;
            prev_seq_next  = sequence_number;
            have_prev_next = 1'b1;
            if (!half_base)
            begin
                load_half      = 1'b1;
                have_half_next = 1'b1;
            end
            else
            begin
                info.pair_valid = 1'b1;
                red_average     = red_sum[SAMPLE_BITS:1];
                ir_average      = ir_sum[SAMPLE_BITS:1];
                pairs_next      = pairs_next + COUNT_ONE;
                have_half_next  = 1'b0;
            end
        end

        info.source_count  = accepted_next;
        info.pair_count    = pairs_next;
        info.restart_count = restarts_next;
    end

    // Hold stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            prev_ts_reg   <= '0;
            prev_seq_reg  <= '0;
            have_half_reg <= 1'b0;
            accepted_reg  <= '0;
            pairs_reg     <= '0;
            restarts_reg  <= '0;
        end
        else
        begin
            have_prev_reg <= have_prev_next;
            prev_ts_reg   <= prev_ts_next;
            prev_seq_reg  <= prev_seq_next;
            have_half_reg <= have_half_next;
            accepted_reg  <= accepted_next;
            pairs_reg     <= pairs_next;
            restarts_reg  <= restarts_next;
        end
    end

    // Hold the first half of a pair
    always_ff @(posedge clk)
    begin
        if (load_half)
        begin
            held_red_reg <= red_level;
            held_ir_reg  <= ir_level;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ppg_pair_decimator_with_continuity.sv =====
`default_nettype none

// Channel   Role   Moves
// -------   ----   -----------------------------------------------------------
// samples   sink   timestamp, sequence number, flags, red and IR levels
// pairs     source pair valid, averages, status, source/pair/restart counts
// cfg       sink   register index and write data, always ready
//
// One item per cycle sustained while pairs.ready is high; a taken item sits
// in the input register while checks, pair average and state update run, and
// the outcome lands in the result register, which drives the pairs port.
// Reset clears the stream state, the counters and the registers to defaults.
// A stalled result holds the result register; the input register still takes
// one more item, then samples.ready drops until the result is taken.

module ppg_pair_decimator_with_continuity #(
    parameter int SAMPLE_BITS = ppgd_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ppgd_in_if.sink    samples,
    ppgd_out_if.source pairs,
    ppgd_cfg_if.sink   cfg
);
    import ppgd_pkg::*;

    // Input register
    logic                   in_valid_reg, in_valid_next;
    logic [TS_BITS-1:0]     ts_reg;
    logic [SEQ_BITS-1:0]    seq_reg;
    logic [FLAG_BITS-1:0]   flags_reg;
    logic [SAMPLE_BITS-1:0] red_reg;
    logic [SAMPLE_BITS-1:0] ir_reg;

    // Result register
    logic                   out_valid_reg, out_valid_next;
    res_info_t              info_reg;
    logic [SAMPLE_BITS-1:0] red_avg_reg;
    logic [SAMPLE_BITS-1:0] ir_avg_reg;

    cfg_state_t             cfg_state;
    res_info_t              info;
    logic [SAMPLE_BITS-1:0] red_avg;
    logic [SAMPLE_BITS-1:0] ir_avg;
    logic                   advance;
    logic                   in_fire;

    ppgd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_state (cfg_state)
    );

    ppgd_step #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_step (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_state       (cfg_state),
        .fire            (advance),
        .capture_time    (ts_reg),
        .sequence_number (seq_reg),
        .sample_flags    (flags_reg),
        .red_level       (red_reg),
        .ir_level        (ir_reg),
        .info            (info),
        .red_average     (red_avg),
        .ir_average      (ir_avg)
    );

    // Advance the held item when the result register is free
    assign advance       = in_valid_reg && (!out_valid_reg || pairs.ready);
    assign samples.ready = !in_valid_reg || advance;
    assign in_fire       = samples.valid && samples.ready;

    always_comb
    begin
        in_valid_next = in_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (pairs.ready ? 1'b0 : out_valid_reg);
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the incoming item
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ts_reg    <= samples.capture_time;
            seq_reg   <= samples.sequence_number;
            flags_reg <= samples.sample_flags;
            red_reg   <= samples.red_level;
            ir_reg    <= samples.ir_level;
        end
    end

    // Capture the result
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            info_reg    <= info;
            red_avg_reg <= red_avg;
            ir_avg_reg  <= ir_avg;
        end
    end

    assign pairs.valid         = out_valid_reg;
    assign pairs.pair_valid    = info_reg.pair_valid;
    assign pairs.red_average   = red_avg_reg;
    assign pairs.ir_average    = ir_avg_reg;
    assign pairs.sample_status = info_reg.status;
    assign pairs.source_count  = info_reg.source_count;
    assign pairs.pair_count    = info_reg.pair_count;
    assign pairs.restart_count = info_reg.restart_count;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ppgd_pkg::*;

    localparam int SB               = SAMPLE_BITS_DEF;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int SHOWN_MISMATCHES = 10;
    localparam int IDLE_PCT         = 14;
    localparam int DRAIN_CYCLES     = 8;

    // Indexes past the register list; writes there must be ignored
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_LOW  = 8'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_HIGH = 8'hFF;

    typedef logic [SB-1:0] level_t;

    typedef struct packed {
        logic                  pair_valid;
        level_t                red_average;
        level_t                ir_average;
        status_t               status;
        logic [COUNT_BITS-1:0] source_count;
        logic [COUNT_BITS-1:0] pair_count;
        logic [COUNT_BITS-1:0] restart_count;
    } pair_result_t;

    // Kinds of broken items mixed into the random streams
    typedef enum int {
        NOISE_TS_JUMP,
        NOISE_TS_REPEAT,
        NOISE_SEQ_JUMP,
        NOISE_SEQ_REPEAT,
        NOISE_FLAGGED,
        NOISE_ALL
    } noise_t;

    logic clk;
    logic rst_n;

    ppgd_in_if  #(.SAMPLE_BITS(SB)) samples ();
    ppgd_out_if #(.SAMPLE_BITS(SB)) pairs ();
    ppgd_cfg_if                     cfg ();

    ppg_pair_decimator_with_continuity #(.SAMPLE_BITS(SB)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .pairs   (pairs),
        .cfg     (cfg)
    );

    // Decimator state as the checker tracks it
    logic [RATE_BITS-1:0]   rate_reg     = RATE_RESET;
    logic [PERIOD_BITS-1:0] period_reg   = PERIOD_RESET;
    logic [MASK_BITS-1:0]   mask_reg     = MASK_RESET;
    logic                   have_prev    = 1'b0;
    logic [TS_BITS-1:0]     prev_ts      = '0;
    logic [SEQ_BITS-1:0]    prev_seq     = '0;
    logic                   half_held    = 1'b0;
    level_t                 held_red     = '0;
    level_t                 held_ir      = '0;
    logic [COUNT_BITS-1:0]  accepted_cnt = '0;
    logic [COUNT_BITS-1:0]  pair_cnt     = '0;
    logic [COUNT_BITS-1:0]  restart_cnt  = '0;

    pair_result_t expected_pairs [$];

    bit                  steady = 1'b0;
    int                  errors = 0;
    int                  cycles = 0;
    int                  items_taken = 0;
    int                  results_seen = 0;
    int                  pairs_seen = 0;
    int                  status_seen [4] = '{0, 0, 0, 0};
    logic [TS_BITS-1:0]  stream_ts;
    logic [SEQ_BITS-1:0] stream_seq;

    // Clear the pending half, continuity and counts; bump the restart count
    function automatic void restart_decimation();
        accepted_cnt = '0;
        pair_cnt     = '0;
        half_held    = 1'b0;
        have_prev    = 1'b0;
        prev_ts      = '0;
        prev_seq     = '0;
        restart_cnt  = restart_cnt + COUNT_ONE;
    endfunction

    // A changing write restarts the stream; same value or unknown index does nothing
    function automatic void apply_reg_write(logic [CFG_INDEX_BITS-1:0] idx,
                                            logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            REG_SAMPLE_RATE:
                if (rate_reg != data[RATE_BITS-1:0])
                begin
                    rate_reg = data[RATE_BITS-1:0];
                    restart_decimation();
                end
            REG_SAMPLE_PERIOD:
                if (period_reg != data[PERIOD_BITS-1:0])
                begin
                    period_reg = data[PERIOD_BITS-1:0];
                    restart_decimation();
                end
            REG_DISC_MASK:
                if (mask_reg != data[MASK_BITS-1:0])
                begin
                    mask_reg = data[MASK_BITS-1:0];
                    restart_decimation();
                end
            default: ;
        endcase
    endfunction

    // Work out the result of one sample and advance the tracked state
    function automatic pair_result_t average_sample(logic [TS_BITS-1:0] ts,
                                                    logic [SEQ_BITS-1:0] seq,
                                                    logic [FLAG_BITS-1:0] flags,
                                                    level_t red, level_t ir);
        pair_result_t r;
        logic [SB:0]  red_sum;
        logic [SB:0]  ir_sum;
        logic         flagged;
        logic         seq_gap;
        logic         ts_gap;
        r = '0;
        r.status = STATUS_ACCEPTED;
        if (rate_reg != SUPPORTED_RATE_HZ)
        begin
            r.status = STATUS_RATE_IGNORED;
        end
        else if (have_prev && (ts <= prev_ts || seq == prev_seq))
        begin
            restart_decimation();
            r.status = STATUS_DROPPED;
        end
        else
        begin
            flagged = (flags & mask_reg) != '0;
            seq_gap = have_prev && (seq != prev_seq + SEQ_ONE);
            ts_gap  = have_prev && (ts != prev_ts + TS_BITS'(period_reg));
            if (flagged || seq_gap || ts_gap)
            begin
                restart_decimation();
                r.status = STATUS_RESTARTED;
            end
            accepted_cnt = accepted_cnt + COUNT_ONE;
            if (!half_held)
            begin
                held_red  = red;
                held_ir   = ir;
                half_held = 1'b1;
            end
            else
            begin
                // Round half up: (a + b + 1) / 2 with one extra bit of headroom
                red_sum       = {1'b0, held_red} + {1'b0, red} + 1'b1;
                ir_sum        = {1'b0, held_ir} + {1'b0, ir} + 1'b1;
                r.pair_valid  = 1'b1;
                r.red_average = red_sum[SB:1];
                r.ir_average  = ir_sum[SB:1];
                pair_cnt      = pair_cnt + COUNT_ONE;
                half_held     = 1'b0;
            end
            prev_ts   = ts;
            prev_seq  = seq;
            have_prev = 1'b1;
        end
        r.source_count  = accepted_cnt;
        r.pair_count    = pair_cnt;
        r.restart_count = restart_cnt;
        return r;
    endfunction

    function automatic void report_error(string msg);
        errors++;
        if (errors <= SHOWN_MISMATCHES)
            $display("%s", msg);
    endfunction

    // Compare one result item against the oldest expectation
    function automatic void check_result();
        pair_result_t got;
        pair_result_t want;
        got.pair_valid    = pairs.pair_valid;
        got.red_average   = pairs.red_average;
        got.ir_average    = pairs.ir_average;
        got.status        = status_t'(pairs.sample_status);
        got.source_count  = pairs.source_count;
        got.pair_count    = pairs.pair_count;
        got.restart_count = pairs.restart_count;
        results_seen++;
        if (expected_pairs.size() == 0)
        begin
            report_error($sformatf("result with nothing expected at cycle %0d", cycles));
            return;
        end
        want = expected_pairs.pop_front();
        if (want.pair_valid)
            pairs_seen++;
        status_seen[want.status]++;
        if (got !== want)
            report_error($sformatf({"mismatch at cycle %0d:\n",
                "  exp pv=%0d red=%h ir=%h st=%0d src=%0d pairs=%0d restarts=%0d\n",
                "  got pv=%0d red=%h ir=%h st=%0d src=%0d pairs=%0d restarts=%0d"},
                cycles,
                want.pair_valid, want.red_average, want.ir_average, want.status,
                want.source_count, want.pair_count, want.restart_count,
                got.pair_valid, got.red_average, got.ir_average, got.status,
                got.source_count, got.pair_count, got.restart_count));
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watch every handshake: register writes, samples in, results out
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
                apply_reg_write(cfg.index, cfg.data);
            if (samples.valid && samples.ready)
            begin
                items_taken++;
                expected_pairs.push_back(average_sample(samples.capture_time,
                    samples.sequence_number, samples.sample_flags,
                    samples.red_level, samples.ir_level));
            end
            if (pairs.valid && pairs.ready)
                check_result();
        end
    end

    // Stall the result side at random unless in a steady stretch
    always @(posedge clk)
    begin
        pairs.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic level_t rand_level();
        if ($urandom_range(7) == 0)
            return ($urandom_range(1) != 0) ? {SB{1'b1}} : {SB{1'b0}};
        return level_t'($urandom);
    endfunction

    // Offer one item, with a random gap first, and hold it until taken
    task automatic send_sample(input logic [TS_BITS-1:0] ts,
                               input logic [SEQ_BITS-1:0] seq,
                               input logic [FLAG_BITS-1:0] flags,
                               input level_t red, input level_t ir);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            samples.valid <= 1'b0;
            @(posedge clk);
        end
        samples.valid           <= 1'b1;
        samples.capture_time    <= ts;
        samples.sequence_number <= seq;
        samples.sample_flags    <= flags;
        samples.red_level       <= red;
        samples.ir_level        <= ir;
        do @(posedge clk); while (!samples.ready);
    endtask

    // Stop offering items and wait until every result has come back
    task automatic drain_pairs();
        samples.valid <= 1'b0;
        @(posedge clk);
        while (expected_pairs.size() != 0)
            @(posedge clk);
    endtask

    // Write one register once the block is idle
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        drain_pairs();
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    // Mostly well-formed continuation of the stream, with some broken items
    task automatic run_stream(input int count, input int noise_pct);
        logic [TS_BITS-1:0]   ts;
        logic [SEQ_BITS-1:0]  seq;
        logic [FLAG_BITS-1:0] flags;
        noise_t               kind;
        for (int i = 0; i < count; i++)
        begin
            ts    = stream_ts + TS_BITS'(period_reg);
            seq   = stream_seq + SEQ_ONE;
            flags = FLAG_BITS'($urandom_range(255)) & ~mask_reg;
            if ($urandom_range(99) < noise_pct)
            begin
                kind = noise_t'($urandom_range(NOISE_ALL));
                case (kind)
                    NOISE_TS_JUMP:    ts = $urandom;
                    NOISE_TS_REPEAT:  ts = stream_ts;
                    NOISE_SEQ_JUMP:   seq = $urandom;
                    NOISE_SEQ_REPEAT: seq = stream_seq;
                    NOISE_FLAGGED:    flags = FLAG_BITS'($urandom_range(255));
                    default:
                    begin
                        ts    = $urandom;
                        seq   = $urandom;
                        flags = FLAG_BITS'($urandom_range(255));
                    end
                endcase
            end
            send_sample(ts, seq, flags, rand_level(), rand_level());
            stream_ts  = ts;
            stream_seq = seq;
        end
    endtask

    // Full-scale and rounding pairs, unmasked flag bits
    task automatic test_pairing_extremes();
        send_sample(32'd0, 32'd0, 8'h00, {SB{1'b1}}, {SB{1'b0}});
        send_sample(32'd5000, 32'd1, 8'h00, {SB{1'b1}}, level_t'(1));
        send_sample(32'd10000, 32'd2, 8'h00, {SB{1'b0}}, {SB{1'b1}});
        send_sample(32'd15000, 32'd3, 8'h00, level_t'(1), level_t'(24'hFFFFFE));
        send_sample(32'd20000, 32'd4, 8'hFC, level_t'(24'h123456), level_t'(24'hABCDEF));
    endtask

    // Flags, gaps, repeats, backward time and wraparound
    task automatic test_continuity_breaks();
        send_sample(32'd25000, 32'd5, 8'h01, rand_level(), rand_level());
        send_sample(32'd30000, 32'd6, 8'h02, rand_level(), rand_level());
        send_sample(32'd35000, 32'd8, 8'h00, rand_level(), rand_level());
        send_sample(32'd39999, 32'd9, 8'h00, rand_level(), rand_level());
        send_sample(32'd39999, 32'd10, 8'h00, rand_level(), rand_level());
        send_sample(32'd44999, 32'd11, 8'h00, rand_level(), rand_level());
        send_sample(32'd49999, 32'd11, 8'h00, rand_level(), rand_level());
        send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, rand_level(), rand_level());
        send_sample(32'd4999, 32'd0, 8'h00, rand_level(), rand_level());
        send_sample(32'd100, 32'hFFFF_FFFF, 8'h00, rand_level(), rand_level());
        send_sample(32'd5100, 32'd0, 8'h00, rand_level(), rand_level());
    endtask

    // Unsupported rates ignore every sample and leave counts alone
    task automatic test_rate_mismatch();
        write_reg(REG_SAMPLE_RATE, 32'd0);
        send_sample(32'd5000, 32'd1, 8'h00, rand_level(), rand_level());
        send_sample(32'd10000, 32'd2, 8'hFF, rand_level(), rand_level());
        write_reg(REG_SAMPLE_RATE, 32'hFFFF_FFFF);
        send_sample(32'd15000, 32'd3, 8'h00, rand_level(), rand_level());
        // upper data bits are dropped, leaving the supported rate
        write_reg(REG_SAMPLE_RATE, 32'h0001_00C8);
        send_sample(32'd20000, 32'd4, 8'h00, rand_level(), rand_level());
    endtask

    // Same-value and unknown-index writes, mask and period extremes
    task automatic test_register_writes();
        write_reg(REG_DISC_MASK, 32'hFFFF_FF03);
        write_reg(REG_UNUSED_LOW, 32'hFFFF_FFFF);
        write_reg(REG_UNUSED_HIGH, 32'd0);
        write_reg(REG_DISC_MASK, 32'd0);
        send_sample(32'd1000, 32'd7, 8'hFF, rand_level(), rand_level());
        write_reg(REG_DISC_MASK, 32'hFF);
        send_sample(32'd6000, 32'd8, 8'h00, rand_level(), rand_level());
        // zero period: any later timestamp is a gap
        write_reg(REG_SAMPLE_PERIOD, 32'd0);
        send_sample(32'd50, 32'd1, 8'h00, rand_level(), rand_level());
        send_sample(32'd50, 32'd2, 8'h00, rand_level(), rand_level());
        send_sample(32'd60, 32'd3, 8'h00, rand_level(), rand_level());
        send_sample(32'd70, 32'd4, 8'h00, rand_level(), rand_level());
        write_reg(REG_SAMPLE_PERIOD, 32'hFFF0_0001);
        send_sample(32'd10, 32'd0, 8'h00, rand_level(), rand_level());
        send_sample(32'd11, 32'd1, 8'h00, rand_level(), rand_level());
        write_reg(REG_SAMPLE_PERIOD, 32'h000F_FFFF);
        send_sample(32'd0, 32'd5, 8'h00, rand_level(), rand_level());
        send_sample(32'h000F_FFFF, 32'd6, 8'h00, rand_level(), rand_level());
        write_reg(REG_SAMPLE_PERIOD, 32'd5000);
        write_reg(REG_DISC_MASK, 32'd3);
    endtask

    // Long random streams under several register settings
    task automatic test_random_streams();
        stream_ts  = $urandom_range(1000);
        stream_seq = $urandom;
        steady = 1'b1;
        run_stream(60, 10);
        steady = 1'b0;
        run_stream(60, 20);
        write_reg(REG_SAMPLE_PERIOD, 32'd1);
        write_reg(REG_DISC_MASK, 32'hFF);
        run_stream(90, 20);
        write_reg(REG_SAMPLE_PERIOD, 32'd1000000);
        write_reg(REG_DISC_MASK, 32'h80);
        // start near the top so the timestamp wraps
        stream_ts = 32'hFFF0_0000;
        run_stream(90, 20);
        write_reg(REG_SAMPLE_PERIOD, 32'h000F_FFFF);
        write_reg(REG_DISC_MASK, 32'd0);
        run_stream(80, 25);
        write_reg(REG_SAMPLE_RATE, 32'd199);
        run_stream(10, 20);
        write_reg(REG_SAMPLE_RATE, 32'd200);
        write_reg(REG_SAMPLE_PERIOD, 32'd5000);
        write_reg(REG_DISC_MASK, 32'd3);
        run_stream(30, 20);
    endtask

    initial
    begin
        rst_n                   <= 1'b0;
        samples.valid           <= 1'b0;
        samples.capture_time    <= '0;
        samples.sequence_number <= '0;
        samples.sample_flags    <= '0;
        samples.red_level       <= '0;
        samples.ir_level        <= '0;
        cfg.valid               <= 1'b0;
        cfg.index               <= '0;
        cfg.data                <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pairing_extremes();
        test_continuity_breaks();
        test_rate_mismatch();
        test_register_writes();
        test_random_streams();

        drain_pairs();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_pairs.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_pairs.size()));

        $display("run covered %0d samples and %0d results, %0d of them averaged pairs",
                 items_taken, results_seen, pairs_seen);
        $display("status mix accepted/ignored/dropped/restarted %0d/%0d/%0d/%0d, %0d errors",
                 status_seen[STATUS_ACCEPTED], status_seen[STATUS_RATE_IGNORED],
                 status_seen[STATUS_DROPPED], status_seen[STATUS_RESTARTED], errors);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ppgd_pkg.sv
rtl/ppgd_if.sv
rtl/ppgd_cfg_regs.sv
rtl/ppgd_step.sv
rtl/ppg_pair_decimator_with_continuity.sv
tb/tb_top.sv
